@@ src/eth_vlan_ipv4_udp_header_parser_defines.svh @@
// ============================================================================
// Assertion macros for the Ethernet/VLAN/IPv4/UDP header parser
// Shared property templates, clocked on i_clk and qualified by i_rst_n.
// ============================================================================
`ifndef ETH_VLAN_IPV4_UDP_HEADER_PARSER_DEFINES_SVH
`define ETH_VLAN_IPV4_UDP_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define EVUHP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that a signal is low in the cycle after reset is applied.
`define EVUHP_ASSERT_RST_LOW(label, sig, msg) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> !(sig)) \
        else $error(msg);

`endif

@@ src/evuhp_pkg.sv @@
// ============================================================================
// evuhp_pkg
// Constants, status codes and the front-to-back command type of the parser.
// ============================================================================
package evuhp_pkg;

    // Bytes past this position are dropped; the frame is judged at this length.
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [15:0] TYPE_VLAN = 16'h8100;
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;

    localparam int DST_MAC_END    = 6;
    localparam int SRC_MAC_END    = 12;
    localparam int OTYPE_HI_POS   = 12;
    localparam int ETH_HDR_BYTES  = 14;
    localparam int TAG_WORD_END   = 16;
    localparam int VLAN_HDR_BYTES = 18;
    localparam int IP_ADDR_REL    = 12;
    localparam int IP_ADDR_END    = 20;
    localparam int UDP_PORT_BYTES = 4;
    localparam int UDP_HDR_BYTES  = 8;

    // Command queue between front and back; depth is a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_TYPE  = 2'd1,
        ST_SHORT_IP  = 2'd2,
        ST_TRUNCATED = 2'd3
    } t_status;

    // One classified byte: where it lands, and on the last byte the verdict.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_status    status;
        logic [6:0] payload_offset;
        logic       dst_we;
        logic       src_we;
        logic [2:0] mac_idx;
        logic       tag_we;
        logic       tag_idx;
        logic       ip_we;
        logic [2:0] ip_idx;
        logic       udp_we;
        logic [1:0] udp_idx;
    } t_cmd;

endpackage

@@ src/evuhp_in_if.sv @@
// ============================================================================
// evuhp_in_if
// Byte channel into the parser: one frame byte and an end-of-frame mark.
// ============================================================================
interface evuhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ src/evuhp_out_if.sv @@
// ============================================================================
// evuhp_out_if
// Result channel of the parser: one header summary per frame.
// ============================================================================
interface evuhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] eth_type;
    logic [11:0] vlan_id;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [15:0] udp_src;
    logic [15:0] udp_dst;
    logic [6:0]  payload_offset;

    modport source (output valid, output status, output dst_mac, output src_mac,
                    output eth_type, output vlan_id, output ip_src, output ip_dst,
                    output udp_src, output udp_dst, output payload_offset,
                    input ready);
    modport sink   (input valid, input status, input dst_mac, input src_mac,
                    input eth_type, input vlan_id, input ip_src, input ip_dst,
                    input udp_src, input udp_dst, input payload_offset,
                    output ready);
endinterface

@@ src/evuhp_front.sv @@
// ============================================================================
// evuhp_front
// Tracks the byte position and header layout and classifies each byte.
// ============================================================================
module evuhp_front import evuhp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    evuhp_in_if.sink    i_in,
    input  logic        i_queue_ready,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_tagged, n_tagged;
    logic [3:0]       r_ihl, n_ihl;
    logic             r_err, n_err;
    logic [7:0]       r_hi_byte, n_hi_byte;

    logic             take;
    logic             in_ip;
    logic [POS_W-1:0] ip_start;
    logic [POS_W-1:0] rel;
    logic [POS_W-1:0] ip_rel;
    logic [POS_W-1:0] udp_at;
    logic [3:0]       hdr_words;
    logic [15:0]      pair;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] ip_start_n;
    logic [POS_W-1:0] hdr_n;
    logic [POS_W-1:0] poff;

    assign i_in.ready = i_queue_ready;
    assign o_push     = i_in.valid && i_queue_ready;

    always_comb begin
        take      = r_pos < POS_W'(MAX_FRAME_BYTES);
        ip_start  = r_tagged ? POS_W'(VLAN_HDR_BYTES) : POS_W'(ETH_HDR_BYTES);
        rel       = r_pos - ip_start;
        ip_rel    = rel - POS_W'(IP_ADDR_REL);
        in_ip     = take && (r_pos >= ip_start);
        pair      = {r_hi_byte, i_in.data_byte};

        n_pos     = take ? r_pos + POS_W'(1) : r_pos;
        n_tagged  = r_tagged;
        n_ihl     = r_ihl;
        n_err     = r_err;
        n_hi_byte = r_hi_byte;

        o_cmd      = '0;
        o_cmd.data = i_in.data_byte;
        o_cmd.last = i_in.last_byte;

        // Ethernet and VLAN portion of the header.
        if (take) begin
            if (r_pos < POS_W'(DST_MAC_END)) begin
                o_cmd.dst_we  = 1'b1;
                o_cmd.mac_idx = r_pos[2:0];
            end else if (r_pos < POS_W'(SRC_MAC_END)) begin
                o_cmd.src_we  = 1'b1;
                o_cmd.mac_idx = 3'(r_pos - POS_W'(DST_MAC_END));
            end else if (r_pos < POS_W'(ETH_HDR_BYTES)) begin
                if (r_pos == POS_W'(OTYPE_HI_POS)) begin
                    n_hi_byte = i_in.data_byte;
                end else begin
                    n_tagged = (pair == TYPE_VLAN);
                    if (pair != TYPE_VLAN && pair != TYPE_IPV4) begin
                        n_err = 1'b1;
                    end
                end
            end else if (r_tagged && r_pos < POS_W'(VLAN_HDR_BYTES)) begin
                if (r_pos < POS_W'(TAG_WORD_END)) begin
                    o_cmd.tag_we  = 1'b1;
                    o_cmd.tag_idx = r_pos[0];
                end else if (r_pos == POS_W'(TAG_WORD_END)) begin
                    n_hi_byte = i_in.data_byte;
                end else if (pair != TYPE_IPV4) begin
                    n_err = 1'b1;
                end
            end
        end

        // IPv4 and UDP portion; the IHL byte already moves the UDP window.
        hdr_words = (in_ip && rel == '0) ? i_in.data_byte[3:0] : r_ihl;
        if (in_ip && rel == '0) begin
            n_ihl = i_in.data_byte[3:0];
        end
        udp_at = POS_W'({hdr_words, 2'b00});

        if (in_ip && rel >= POS_W'(IP_ADDR_REL) && rel < POS_W'(IP_ADDR_END)) begin
            o_cmd.ip_we  = 1'b1;
            o_cmd.ip_idx = ip_rel[2:0];
        end
        if (in_ip && rel >= udp_at && rel < udp_at + POS_W'(UDP_PORT_BYTES)) begin
            o_cmd.udp_we  = 1'b1;
            o_cmd.udp_idx = rel[1:0];
        end

        // Frame verdict, judged on the state after this byte.
        len        = n_pos;
        ip_start_n = n_tagged ? POS_W'(VLAN_HDR_BYTES) : POS_W'(ETH_HDR_BYTES);
        hdr_n      = POS_W'({n_ihl, 2'b00});
        poff       = ip_start_n + hdr_n + POS_W'(UDP_HDR_BYTES);

        if (len < POS_W'(ETH_HDR_BYTES) || (n_tagged && len < POS_W'(VLAN_HDR_BYTES))) begin
            o_cmd.status = ST_TRUNCATED;
        end else if (n_err) begin
            o_cmd.status = ST_BAD_TYPE;
        end else if (len <= ip_start_n || (len - ip_start_n) < hdr_n) begin
            o_cmd.status = ST_SHORT_IP;
        end else if (len < ip_start_n + hdr_n + POS_W'(UDP_PORT_BYTES)) begin
            o_cmd.status = ST_TRUNCATED;
        end else begin
            o_cmd.status = ST_OK;
        end
        o_cmd.payload_offset = poff[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_tagged  <= 1'b0;
            r_ihl     <= '0;
            r_err     <= 1'b0;
            r_hi_byte <= '0;
        end else if (o_push) begin
            if (i_in.last_byte) begin
                r_pos     <= '0;
                r_tagged  <= 1'b0;
                r_ihl     <= '0;
                r_err     <= 1'b0;
                r_hi_byte <= '0;
            end else begin
                r_pos     <= n_pos;
                r_tagged  <= n_tagged;
                r_ihl     <= n_ihl;
                r_err     <= n_err;
                r_hi_byte <= n_hi_byte;
            end
        end
    end

endmodule

@@ src/evuhp_fifo.sv @@
// ============================================================================
// evuhp_fifo
// Short command queue that decouples the front from the back.
// ============================================================================
module evuhp_fifo import evuhp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_head
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_ready = r_count != (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QUEUE_AW + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QUEUE_AW + 1)'(1);
            end
        end
    end

endmodule

@@ src/evuhp_back.sv @@
// ============================================================================
// evuhp_back
// Captures header fields from classified bytes and holds the result register.
// ============================================================================
module evuhp_back import evuhp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    evuhp_out_if.source o_out
);

    logic [47:0] r_dst, n_dst;
    logic [47:0] r_src, n_src;
    logic [15:0] r_tag, n_tag;
    logic [63:0] r_ip, n_ip;
    logic [31:0] r_udp, n_udp;

    logic        r_out_valid;
    t_status     r_status;
    logic [47:0] r_o_dst;
    logic [47:0] r_o_src;
    logic [15:0] r_o_type;
    logic [11:0] r_o_vid;
    logic [63:0] r_o_ip;
    logic [31:0] r_o_udp;
    logic [6:0]  r_o_poff;

    logic        out_free;
    logic        frame_ok;

    assign out_free  = !r_out_valid || o_out.ready;
    assign o_cmd_pop = i_cmd_valid && (!i_cmd.last || out_free);
    assign frame_ok  = i_cmd.status == ST_OK;

    // Byte lanes count down from the most significant end of each field.
    always_comb begin
        n_dst = r_dst;
        n_src = r_src;
        n_tag = r_tag;
        n_ip  = r_ip;
        n_udp = r_udp;
        if (i_cmd.dst_we) begin
            n_dst[{3'(3'd5 - i_cmd.mac_idx), 3'b000} +: 8] = i_cmd.data;
        end
        if (i_cmd.src_we) begin
            n_src[{3'(3'd5 - i_cmd.mac_idx), 3'b000} +: 8] = i_cmd.data;
        end
        if (i_cmd.tag_we) begin
            n_tag[{~i_cmd.tag_idx, 3'b000} +: 8] = i_cmd.data;
        end
        if (i_cmd.ip_we) begin
            n_ip[{~i_cmd.ip_idx, 3'b000} +: 8] = i_cmd.data;
        end
        if (i_cmd.udp_we) begin
            n_udp[{~i_cmd.udp_idx, 3'b000} +: 8] = i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst <= '0;
            r_src <= '0;
            r_tag <= '0;
            r_ip  <= '0;
            r_udp <= '0;
        end else if (o_cmd_pop) begin
            if (i_cmd.last) begin
                r_dst <= '0;
                r_src <= '0;
                r_tag <= '0;
                r_ip  <= '0;
                r_udp <= '0;
            end else begin
                r_dst <= n_dst;
                r_src <= n_src;
                r_tag <= n_tag;
                r_ip  <= n_ip;
                r_udp <= n_udp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd_pop && i_cmd.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Every field but the status reads as zero on a rejected frame.
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.last) begin
            r_status <= i_cmd.status;
            r_o_dst  <= frame_ok ? n_dst : '0;
            r_o_src  <= frame_ok ? n_src : '0;
            r_o_type <= frame_ok ? TYPE_IPV4 : '0;
            r_o_vid  <= frame_ok ? n_tag[11:0] : '0;
            r_o_ip   <= frame_ok ? n_ip : '0;
            r_o_udp  <= frame_ok ? n_udp : '0;
            r_o_poff <= frame_ok ? i_cmd.payload_offset : '0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_status;
    assign o_out.dst_mac        = r_o_dst;
    assign o_out.src_mac        = r_o_src;
    assign o_out.eth_type       = r_o_type;
    assign o_out.vlan_id        = r_o_vid;
    assign o_out.ip_src         = r_o_ip[63:32];
    assign o_out.ip_dst         = r_o_ip[31:0];
    assign o_out.udp_src        = r_o_udp[31:16];
    assign o_out.udp_dst        = r_o_udp[15:0];
    assign o_out.payload_offset = r_o_poff;

endmodule

@@ src/eth_vlan_ipv4_udp_header_parser.sv @@
// ============================================================================
// eth_vlan_ipv4_udp_header_parser
// Streams a frame byte by byte and reports its Ethernet, VLAN, IPv4 and UDP
// header fields once per frame.
// ============================================================================
//
//  Channel  Port   Direction  Transfer moves
//  -------  -----  ---------  ------------------------------------------------
//  input    i_in   sink       one frame byte plus the end-of-frame mark
//  output   o_out  source     one header summary and status per frame
//
// One byte transfer is taken per cycle while the queue has room; the front
// classifies it in the same cycle and writes one command into a four-entry queue.
// The result of a frame passes from the transfer of its last byte through the
// queue and is then registered in the back's output register.
// Reset is synchronous and active low; it clears the position counter, the
// queue pointers and the output valid flag. No clearing pass is needed.
// A stalled output holds the result; bytes keep flowing until the queue is
// full, which only happens when the output stays stalled.
//
`include "eth_vlan_ipv4_udp_header_parser_defines.svh"

module eth_vlan_ipv4_udp_header_parser import evuhp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    evuhp_in_if.sink    i_in,
    evuhp_out_if.source o_out
);

    // Front to queue.
    logic q_ready;
    logic q_push;
    t_cmd q_push_cmd;

    // Queue to back.
    logic q_valid;
    logic q_pop;
    t_cmd q_head;

    // The front owns the byte position and the layout decisions (tag present,
    // IHL, ether type errors), so each byte leaves it already tagged with its
    // destination lane and, on the last byte, with the frame verdict.
    evuhp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_queue_ready (q_ready),
        .o_push        (q_push),
        .o_cmd         (q_push_cmd)
    );

    // The queue lets the front keep taking bytes while a finished result waits.
    evuhp_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .o_ready    (q_ready),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_head     (q_head)
    );

    // The back writes captured bytes into the field registers and loads the
    // output register when a last-byte command arrives and the slot is free.
    evuhp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_head),
        .o_cmd_pop   (q_pop),
        .o_out       (o_out)
    );

    // A rejected frame must not leak captured fields; checked on dst_mac, udp_src and payload_offset.
    `EVUHP_ASSERT_IMP(a_reject_zeroes, o_out.valid && o_out.status != ST_OK,
        o_out.dst_mac == '0 && o_out.udp_src == '0 && o_out.payload_offset == '0,
        "rejected frame carries captured fields")

    // An accepted frame always reports IPv4 and a payload past the UDP ports.
    `EVUHP_ASSERT_IMP(a_ok_is_ipv4, o_out.valid && o_out.status == ST_OK,
        o_out.eth_type == TYPE_IPV4 &&
        o_out.payload_offset >= 7'(ETH_HDR_BYTES + UDP_HDR_BYTES),
        "accepted frame with bad type or offset")

    // A rejected frame reports neither a VLAN id nor a type.
    `EVUHP_ASSERT_IMP(a_reject_no_tag, o_out.valid && o_out.status != ST_OK,
        o_out.vlan_id == '0 && o_out.eth_type == '0,
        "rejected frame carries tag or type")

    // Reset empties the result slot.
    `EVUHP_ASSERT_RST_LOW(a_reset_idle, o_out.valid, "result valid after reset")

endmodule
